// File: sv/decimal_integer_formatter_unit_defines.svh
// Assertion macros used by the formatter datapath (dif_datapath).
// Clocked by clk_i; the first form is disabled while rst_ni is low.
`ifndef DECIMAL_INTEGER_FORMATTER_UNIT_DEFINES_SVH
`define DECIMAL_INTEGER_FORMATTER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define DIF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("dif assertion failed");
`define DIF_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("dif assertion failed");
`else
`define DIF_ASSERT(lbl, prop)
`define DIF_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: sv/dif_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dif_pkg;

  // Conversion kinds
  localparam logic [1:0] KIND_SDEC    = 2'd0;
  localparam logic [1:0] KIND_UDEC    = 2'd1;
  localparam logic [1:0] KIND_CHAR    = 2'd2;
  localparam logic [1:0] KIND_PERCENT = 2'd3;

  // ASCII codes
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PERCENT = 8'h25;

  localparam int MAX_WIDTH   = 64;
  localparam int VALUE_W     = 32;
  localparam int WIDTH_W     = 7;
  localparam int NUM_DIGITS  = 10;
  localparam int BCD_W       = 4 * NUM_DIGITS;
  localparam int BITS_PER_STEP = 2;
  localparam int CONV_STEPS  = VALUE_W / BITS_PER_STEP;
  localparam int STEP_W      = $clog2(CONV_STEPS);
  localparam int IDX_W       = $clog2(NUM_DIGITS);

  typedef enum logic [1:0] {
    CSEL_SPACE,
    CSEL_SIGN,
    CSEL_DIGIT,
    CSEL_CHAR
  } char_sel_e;

  // controller -> datapath
  typedef struct packed {
    logic      load;
    logic      conv;
    logic      prep;
    logic      push;
    logic      last;
    char_sel_e sel;
    logic      dec_pad;
    logic      dec_idx;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       conv_done;
    logic [1:0] kind;
    logic       has_sign;
    logic       left_just;
    logic       pad_zero;
    logic       pad_one;
    logic       idx_zero;
    logic       slot_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// File: sv/dif_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
`include "decimal_integer_formatter_unit_defines.svh"

module dif_datapath (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire  [1:0]           kind_i,
  input  wire  [31:0]          value_i,
  input  wire                  force_plus_i,
  input  wire                  left_justify_i,
  input  wire  [6:0]           pad_width_i,
  input  wire  dif_pkg::dp_cmd_t cmd_i,
  output dif_pkg::dp_sts_t     sts_o,
  output logic [7:0]           out_char_o,
  output logic                 last_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i
);
  import dif_pkg::*;

  logic [1:0]         kind_q;
  logic               neg_q, sign_q, lj_q;
  logic [WIDTH_W-1:0] width_q;
  logic [7:0]         chr_q;
  logic [VALUE_W-1:0] mag_q, mag_d;
  logic [BCD_W-1:0]   bcd_q, bcd_d;
  logic [STEP_W-1:0]  step_q;
  logic [WIDTH_W-1:0] pad_q;
  logic [IDX_W-1:0]   idx_q;
  logic               out_valid_q, last_q;
  logic [7:0]         out_char_q;

  logic               in_neg;
  logic [IDX_W-1:0]   ndig;
  logic [IDX_W:0]     len;
  logic [WIDTH_W-1:0] pad_calc;
  logic [3:0]         cur_dig;
  logic [7:0]         char_d;
  logic               slot_free;

  // one shift-and-add-3 step
  function automatic logic [BCD_W+VALUE_W-1:0] dabble(input logic [BCD_W+VALUE_W-1:0] s);
    logic [BCD_W+VALUE_W-1:0] t;
    t = s;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (t[VALUE_W + 4*i +: 4] >= 4'd5) begin
        t[VALUE_W + 4*i +: 4] = t[VALUE_W + 4*i +: 4] + 4'd3;
      end
    end
    return {t[BCD_W+VALUE_W-2:0], 1'b0};
  endfunction

  always_comb begin
    logic [BCD_W+VALUE_W-1:0] s;
    s = dabble(dabble({bcd_q, mag_q}));
    bcd_d = s[BCD_W+VALUE_W-1:VALUE_W];
    mag_d = s[VALUE_W-1:0];
  end

  // count of significant digits, at least one
  always_comb begin
    ndig = IDX_W'(1);
    for (int i = 1; i < NUM_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] != 4'd0) begin
        ndig = IDX_W'(i + 1);
      end
    end
  end

  assign len      = {1'b0, ndig} + {{IDX_W{1'b0}}, sign_q};
  assign pad_calc = (width_q > WIDTH_W'(len)) ? (width_q - WIDTH_W'(len)) : '0;
  assign in_neg   = (kind_i == KIND_SDEC) && value_i[VALUE_W-1];
  assign cur_dig  = bcd_q[4*idx_q +: 4];
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    case (cmd_i.sel)
      CSEL_SPACE: char_d = CH_SPACE;
      CSEL_SIGN:  char_d = neg_q ? CH_MINUS : CH_PLUS;
      CSEL_DIGIT: char_d = CH_ZERO | {4'd0, cur_dig};
      CSEL_CHAR:  char_d = chr_q;
      default:    char_d = CH_SPACE;
    endcase
  end

  // item registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_i;
      neg_q   <= in_neg;
      sign_q  <= (kind_i == KIND_SDEC) && (in_neg || force_plus_i);
      lj_q    <= left_justify_i;
      width_q <= (kind_i != KIND_SDEC) ? '0 :
                 (pad_width_i > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : pad_width_i;
      chr_q   <= (kind_i == KIND_PERCENT) ? CH_PERCENT : value_i[7:0];
      mag_q   <= in_neg ? (~value_i + 32'd1) : value_i;
      bcd_q   <= '0;
    end else if (cmd_i.conv) begin
      mag_q   <= mag_d;
      bcd_q   <= bcd_d;
    end
    if (cmd_i.push) begin
      out_char_q <= char_d;
      last_q     <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      pad_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        step_q <= '0;
      end else if (cmd_i.conv) begin
        step_q <= step_q + STEP_W'(1);
      end
      if (cmd_i.prep) begin
        pad_q <= pad_calc;
        idx_q <= ndig - IDX_W'(1);
      end else begin
        if (cmd_i.dec_pad) begin
          pad_q <= pad_q - WIDTH_W'(1);
        end
        if (cmd_i.dec_idx) begin
          idx_q <= idx_q - IDX_W'(1);
        end
      end
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.conv_done = (step_q == STEP_W'(CONV_STEPS - 1));
    sts_o.kind      = kind_q;
    sts_o.has_sign  = sign_q;
    sts_o.left_just = lj_q;
    sts_o.pad_zero  = (pad_q == '0);
    sts_o.pad_one   = (pad_q == WIDTH_W'(1));
    sts_o.idx_zero  = (idx_q == '0);
    sts_o.slot_free = slot_free;
  end

  assign out_char_o  = out_char_q;
  assign last_o      = last_q;
  assign out_valid_o = out_valid_q;

  `DIF_ASSERT(a_push_into_free_slot, cmd_i.push |-> slot_free)
  `DIF_ASSERT(a_bcd_cleared_on_load, cmd_i.load |=> (bcd_q == '0 && step_q == '0))
  `DIF_ASSERT(a_ndig_range, cmd_i.prep |-> (ndig >= IDX_W'(1) && ndig <= IDX_W'(NUM_DIGITS)))
  `DIF_ASSERT(a_pad_no_underflow, cmd_i.dec_pad |-> (pad_q != '0))
  `DIF_ASSERT(a_idx_no_underflow, cmd_i.dec_idx |-> (idx_q != '0))

endmodule

`default_nettype wire

// File: sv/dif_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module dif_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  input  wire  [1:0]         kind_i,
  output logic               in_ready_o,
  input  wire  dif_pkg::dp_sts_t sts_i,
  output dif_pkg::dp_cmd_t   cmd_o
);
  import dif_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_PREP,
    ST_PAD_PRE,
    ST_SIGN,
    ST_DIG,
    ST_PAD_POST,
    ST_CHR
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.sel     = CSEL_SPACE;
    in_ready_o    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = (kind_i == KIND_SDEC || kind_i == KIND_UDEC) ? ST_CONV : ST_CHR;
        end
      end
      ST_CONV: begin
        cmd_o.conv = 1'b1;
        if (sts_i.conv_done) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        if (sts_i.kind == KIND_SDEC && !sts_i.left_just) begin
          state_d = ST_PAD_PRE;
        end else if (sts_i.has_sign) begin
          state_d = ST_SIGN;
        end else begin
          state_d = ST_DIG;
        end
      end
      ST_PAD_PRE: begin
        if (sts_i.pad_zero) begin
          state_d = sts_i.has_sign ? ST_SIGN : ST_DIG;
        end else if (sts_i.slot_free) begin
          cmd_o.push    = 1'b1;
          cmd_o.sel     = CSEL_SPACE;
          cmd_o.dec_pad = 1'b1;
        end
      end
      ST_SIGN: begin
        if (sts_i.slot_free) begin
          cmd_o.push = 1'b1;
          cmd_o.sel  = CSEL_SIGN;
          state_d    = ST_DIG;
        end
      end
      ST_DIG: begin
        if (sts_i.slot_free) begin
          cmd_o.push = 1'b1;
          cmd_o.sel  = CSEL_DIGIT;
          cmd_o.last = sts_i.idx_zero && sts_i.pad_zero;
          if (!sts_i.idx_zero) begin
            cmd_o.dec_idx = 1'b1;
          end else if (sts_i.pad_zero) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_PAD_POST;
          end
        end
      end
      ST_PAD_POST: begin
        if (sts_i.slot_free) begin
          cmd_o.push    = 1'b1;
          cmd_o.sel     = CSEL_SPACE;
          cmd_o.last    = sts_i.pad_one;
          cmd_o.dec_pad = 1'b1;
          if (sts_i.pad_one) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_CHR: begin
        if (sts_i.slot_free) begin
          cmd_o.push = 1'b1;
          cmd_o.sel  = CSEL_CHAR;
          cmd_o.last = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/decimal_integer_formatter_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Formats one printf-style integer conversion per input transaction and
// streams the resulting ASCII characters out one per output transaction,
// with last_o set on the final character. kind_i selects signed decimal
// (optional '-' or forced '+', space padding to pad_width_i on the left, or
// on the right when left_justify_i is set, width saturated at 64), unsigned
// decimal (digits only), a single character (low byte of value_i) or '%'.
// The most negative signed value prints as -2147483648. Decimal kinds run a
// binary-to-BCD conversion (two shift-and-add-3 steps per cycle), then size
// the field, then emit one character per cycle whenever the output register
// is free; no new input is taken until the last character has been pushed.
// Character and percent kinds skip conversion and push their single character.
// The output register lets the next input be taken while the final
// character still waits on out_ready_i.

module decimal_integer_formatter_unit (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [1:0]  kind_i,
  input  wire  [31:0] value_i,
  input  wire         force_plus_i,
  input  wire         left_justify_i,
  input  wire  [6:0]  pad_width_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [7:0]  out_char_o,
  output logic        last_o
);
  import dif_pkg::*;

  dp_cmd_t cmd;  // controller commands
  dp_sts_t sts;  // datapath status

  // sequencing: conversion, field sizing, pad / sign / digits / pad phases, single character
  dif_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // item registers, BCD converter, counters and output register
  dif_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .kind_i         (kind_i),
    .value_i        (value_i),
    .force_plus_i   (force_plus_i),
    .left_justify_i (left_justify_i),
    .pad_width_i    (pad_width_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_char_o     (out_char_o),
    .last_o         (last_o),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i)
  );

endmodule

`default_nettype wire
